// ===== hw/rtl/vrdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrdp_pkg
// Shared types and constants of the VP8/VP9 RTP descriptor length parser.
// ----------------------------------------------------------------------------
package vrdp_pkg;

    // Parse phase: which descriptor byte the parser waits for next
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_VP8_EXT,
        PH_VP8_PIDM,
        PH_VP9_PIDM,
        PH_VP9_PDIFF1,
        PH_VP9_PDIFF2,
        PH_VP9_SS,
        PH_VP9_NG,
        PH_VP9_PG
    } t_phase;

    // Result status codes
    typedef enum logic {
        ST_PARSED    = 1'b0,
        ST_TOO_SHORT = 1'b1
    } t_status;

    // Payload format register codes
    localparam logic FMT_VP8 = 1'b0;
    localparam logic FMT_VP9 = 1'b1;

    // Flag bit positions in the descriptor bytes
    localparam int BIT_X_OR_I   = 7;   // VP8 X / VP9 I, also the M bit of a picture ID
    localparam int BIT_EXT_I    = 7;   // VP8 extension: I
    localparam int BIT_EXT_L    = 6;   // VP8 extension: L
    localparam int BIT_EXT_T    = 5;   // VP8 extension: T
    localparam int BIT_EXT_K    = 4;   // VP8 extension: K
    localparam int BIT_VP9_P    = 6;
    localparam int BIT_VP9_L    = 5;
    localparam int BIT_VP9_F    = 4;
    localparam int BIT_VP9_V    = 1;
    localparam int BIT_PDIFF_N  = 0;
    localparam int BIT_SS_Y     = 4;
    localparam int BIT_SS_G     = 3;

    // One result word
    typedef struct packed {
        t_status     status;
        logic [15:0] length;
    } t_result;

endpackage

// ===== hw/rtl/vrdp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrdp_core
// Parse state and per-byte update. Each accepted byte advances the registered
// state and may raise a single result in that same cycle.
// ----------------------------------------------------------------------------
module vrdp_core #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_packet_start,
    input  logic [15:0]       i_payload_length,
    input  logic              i_format_select,
    output logic              o_res_valid,
    output vrdp_pkg::t_result o_res
);
    import vrdp_pkg::*;

    // Length compare width and count width (count may overshoot by one skip)
    localparam int LEN_W = (LENGTH_WIDTH < 16) ? LENGTH_WIDTH : 16;
    localparam int CW    = LEN_W + 1;

    t_phase          r_phase,  n_phase;
    logic [CW-1:0]   r_pos,    n_pos;
    logic [CW-1:0]   r_count,  n_count;
    logic [7:0]      r_first,  n_first;
    logic [7:0]      r_ext,    n_ext;
    logic [7:0]      r_groups, n_groups;

    logic [CW-1:0]   c_len;
    logic            c_fin;
    logic            c_short;
    logic            go_tail;
    logic            go_layers;
    logic            go_flex;
    logic            go_ss;
    logic            go_groups;

    assign c_len = {1'b0, i_payload_length[LEN_W-1:0]};

    // Next state: head byte or inspected byte, then the shared tail sections
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_count   = r_count;
        n_first   = r_first;
        n_ext     = r_ext;
        n_groups  = r_groups;
        c_fin     = 1'b0;
        c_short   = 1'b0;
        go_tail   = 1'b0;
        go_layers = 1'b0;
        go_flex   = 1'b0;
        go_ss     = 1'b0;
        go_groups = 1'b0;

        if (i_accept && i_packet_start) begin
            n_pos    = '0;
            n_count  = CW'(1);
            n_first  = i_data_byte;
            n_ext    = '0;
            n_groups = '0;
            n_phase  = PH_IDLE;
            if (c_len <= CW'(1)) begin
                c_fin   = 1'b1;
                c_short = 1'b1;
            end else if (i_data_byte[BIT_X_OR_I]) begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_fin   = 1'b1;
                    c_short = 1'b1;
                end else begin
                    n_phase = (i_format_select == FMT_VP9) ? PH_VP9_PIDM : PH_VP8_EXT;
                end
            end else if (i_format_select == FMT_VP8) begin
                c_fin = 1'b1;
            end else begin
                go_layers = 1'b1;
            end
        end else if (i_accept && (r_phase != PH_IDLE)) begin
            n_pos = r_pos + CW'(1);
            // only the byte the descriptor points at is inspected
            if (n_pos + CW'(1) == r_count) begin
                case (r_phase)
                    PH_VP8_EXT: begin
                        n_ext = i_data_byte;
                        if (i_data_byte[BIT_EXT_I]) begin
                            n_count = n_count + CW'(1);
                            if (n_count >= c_len) begin
                                c_fin   = 1'b1;
                                c_short = 1'b1;
                            end else begin
                                n_phase = PH_VP8_PIDM;
                            end
                        end else begin
                            go_tail = 1'b1;
                        end
                    end
                    PH_VP8_PIDM, PH_VP9_PIDM: begin
                        if (i_data_byte[BIT_X_OR_I]) begin
                            n_count = n_count + CW'(1);
                            if (n_count >= c_len) begin
                                c_fin   = 1'b1;
                                c_short = 1'b1;
                            end
                        end
                        if (!c_fin) begin
                            if (r_phase == PH_VP8_PIDM) begin
                                go_tail = 1'b1;
                            end else begin
                                go_layers = 1'b1;
                            end
                        end
                    end
                    PH_VP9_PDIFF1: begin
                        if (i_data_byte[BIT_PDIFF_N]) begin
                            n_count = n_count + CW'(1);
                            if (n_count >= c_len) begin
                                c_fin   = 1'b1;
                                c_short = 1'b1;
                            end else begin
                                n_phase = PH_VP9_PDIFF2;
                            end
                        end else begin
                            go_ss = 1'b1;
                        end
                    end
                    PH_VP9_PDIFF2: begin
                        if (i_data_byte[BIT_PDIFF_N]) begin
                            n_count = n_count + CW'(1);
                            if (n_count >= c_len) begin
                                c_fin   = 1'b1;
                                c_short = 1'b1;
                            end
                        end
                        if (!c_fin) begin
                            go_ss = 1'b1;
                        end
                    end
                    PH_VP9_SS: begin
                        // resolution bytes: four per spatial layer
                        if (i_data_byte[BIT_SS_Y]) begin
                            n_count = n_count + CW'({i_data_byte[7:5], 2'b00}) + CW'(4);
                            if (n_count >= c_len) begin
                                c_fin   = 1'b1;
                                c_short = 1'b1;
                            end
                        end
                        if (!c_fin) begin
                            if (i_data_byte[BIT_SS_G]) begin
                                n_count = n_count + CW'(1);
                                if (n_count >= c_len) begin
                                    c_fin   = 1'b1;
                                    c_short = 1'b1;
                                end else begin
                                    n_phase = PH_VP9_NG;
                                end
                            end else begin
                                c_fin = 1'b1;
                            end
                        end
                    end
                    PH_VP9_NG: begin
                        n_groups  = i_data_byte;
                        go_groups = 1'b1;
                    end
                    PH_VP9_PG: begin
                        // reference count of this group adds its diff bytes
                        n_count = n_count + CW'(i_data_byte[3:2]);
                        if (n_count >= c_len) begin
                            c_fin   = 1'b1;
                            c_short = 1'b1;
                        end else begin
                            n_groups  = r_groups - 8'd1;
                            go_groups = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        // VP8: TL0PICIDX, then TID/KEYIDX
        if (go_tail) begin
            if (n_ext[BIT_EXT_L]) begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_fin   = 1'b1;
                    c_short = 1'b1;
                end
            end
            if (!c_fin && (n_ext[BIT_EXT_T] || n_ext[BIT_EXT_K])) begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_short = 1'b1;
                end
            end
            c_fin = 1'b1;
        end

        // VP9 layer indices: one byte, plus TL0PICIDX when not flexible
        if (go_layers) begin
            if (n_first[BIT_VP9_L]) begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_fin   = 1'b1;
                    c_short = 1'b1;
                end
                if (!c_fin && !n_first[BIT_VP9_F]) begin
                    n_count = n_count + CW'(1);
                    if (n_count >= c_len) begin
                        c_fin   = 1'b1;
                        c_short = 1'b1;
                    end
                end
            end
            go_flex = !c_fin;
        end

        // VP9 flexible-mode reference bytes (I, P and F all set)
        if (go_flex) begin
            if (n_first[BIT_X_OR_I] && n_first[BIT_VP9_P] && n_first[BIT_VP9_F]) begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_fin   = 1'b1;
                    c_short = 1'b1;
                end else begin
                    n_phase = PH_VP9_PDIFF1;
                end
            end else begin
                go_ss = 1'b1;
            end
        end

        // VP9 scalability structure header
        if (go_ss) begin
            if (n_first[BIT_VP9_V]) begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_fin   = 1'b1;
                    c_short = 1'b1;
                end else begin
                    n_phase = PH_VP9_SS;
                end
            end else begin
                c_fin = 1'b1;
            end
        end

        // VP9 picture-group entries
        if (go_groups) begin
            if (n_groups == 8'd0) begin
                c_fin = 1'b1;
            end else begin
                n_count = n_count + CW'(1);
                if (n_count >= c_len) begin
                    c_fin   = 1'b1;
                    c_short = 1'b1;
                end else begin
                    n_phase = PH_VP9_PG;
                end
            end
        end

        if (c_fin) begin
            n_phase = PH_IDLE;
        end
    end

    // Result outputs
    always_comb begin
        o_res_valid = c_fin;
        if (c_short) begin
            o_res.status = ST_TOO_SHORT;
            o_res.length = '0;
        end else begin
            o_res.status = ST_PARSED;
            o_res.length = 16'(n_count[LEN_W-1:0]);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= '0;
            r_count  <= '0;
            r_first  <= '0;
            r_ext    <= '0;
            r_groups <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_first  <= n_first;
            r_ext    <= n_ext;
            r_groups <= n_groups;
        end
    end

endmodule

// ===== hw/rtl/vpx_rtp_descriptor_length_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpx_rtp_descriptor_length_parser
// Results: a result word is written into the result queue registers when the byte
//   that settles it is accepted, and the queue offers it on the master side.
// Throughput: one payload byte per cycle; a two-word result queue stalls input
//   only while both entries are full.
// Reset: synchronous, active low; parser idle, queue empty, format VP8.
// ----------------------------------------------------------------------------
module vpx_rtp_descriptor_length_parser #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // payload bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] payload_length
    input  logic        s_axis_tuser,   // [0] packet_start
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] descriptor_length
    output logic        m_axis_tuser,   // [0] parse_status
    // format register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // format_select
);
    import vrdp_pkg::*;

    logic       r_format;
    logic       s_accept;
    logic       m_accept;
    logic       core_valid;
    t_result    core_res;

    t_result    r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt != 2'd2);
    assign o_cfg_ready   = 1'b1;

    // Format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_VP8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_format <= i_cfg_data;
        end
    end

    vrdp_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (s_accept),
        .i_data_byte      (s_axis_tdata[7:0]),
        .i_packet_start   (s_axis_tuser),
        .i_payload_length (s_axis_tdata[23:8]),
        .i_format_select  (r_format),
        .o_res_valid      (core_valid),
        .o_res            (core_res)
    );

    // Result queue pointers
    always_comb begin
        n_wr  = r_wr ^ core_valid;
        n_rd  = r_rd ^ m_accept;
        n_cnt = r_cnt;
        case ({core_valid, m_accept})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (core_valid) begin
            r_q[r_wr] <= core_res;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q[r_rd].length;
    assign m_axis_tuser  = r_q[r_rd].status;

    // A result is only raised by an accepted byte
    a_res_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_valid |-> s_accept)
        else $error("result raised without an accepted byte");

    // The queue never takes a word while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_valid |-> (r_cnt != 2'd2))
        else $error("result queue overflow");

    // A too-short status always carries a zero length
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_TOO_SHORT)) |-> (m_axis_tdata == 16'd0))
        else $error("too-short result with nonzero length");

    // Queue occupancy follows pushes and pops
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_valid && !m_accept && (r_cnt == 2'd0)) |=> (r_cnt == 2'd1))
        else $error("queue count lost a pushed word");

endmodule
